>>> src/fspd_pkg.sv
// Shared types and constants for the four-step phase decoder.
// No dependencies; imported by every module of the block.
package fspd_pkg;

    localparam int GREY_W       = 8;
    localparam int PERIOD_W     = 8;
    localparam int OFFSET_W     = 16;
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_W     = 32;
    localparam int ANG_W        = 32;
    localparam int PRESCALE     = 20;
    localparam int DIFF_W       = GREY_W + 2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd16;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ANG_W-1:0] ATAN_TURN [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic        [ANG_W-1:0]    ang;
        logic                       zero;
    } t_cordic;

endpackage

>>> src/four_step_phase_decoder.sv
// Four-step phase-shift decoder: one pixel per clock; the result passes through
// 1 difference stage, 30 CORDIC cells and 3 scale stages.
// Throughput is one transaction per cycle; the whole pipeline holds only
// while the output register is full and the consumer is not ready.
// Synchronous active-low reset clears all valid bits and sets the fringe
// period to 16; no clearing pass is needed.
module four_step_phase_decoder import fspd_pkg::*; #(
    parameter int PHASE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [GREY_W-1:0]   i_grey_shift0,
    input  logic [GREY_W-1:0]   i_grey_shift90,
    input  logic [GREY_W-1:0]   i_grey_shift180,
    input  logic [GREY_W-1:0]   i_grey_shift270,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OFFSET_W-1:0] o_pixel_offset,
    // configuration
    input  logic                i_cfg_wr_en,
    input  logic [PERIOD_W-1:0] i_cfg_wr_data
);

    logic                 pipe_en;
    logic [PERIOD_W-1:0]  r_period;
    logic                 r_pre_valid;
    t_cordic              r_pre;
    t_cordic              n_pre;
    logic signed [DIFF_W-1:0] sin_t;
    logic signed [DIFF_W-1:0] cos_t;
    logic signed [DIFF_W-1:0] x0;
    logic signed [DIFF_W-1:0] y0;

    t_cordic cell_data  [CORDIC_ITERS+1];
    logic    cell_valid [CORDIC_ITERS+1];

    // Advance every stage together unless the output transaction is stuck.
    assign pipe_en    = !o_out_valid || i_out_ready;
    assign o_in_ready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_period <= i_cfg_wr_data;
        end
    end

    // Form sine and cosine terms, pre-rotate by half a turn when cos < 0,
    // and scale up for CORDIC headroom.
    always_comb begin
        sin_t = $signed({2'b00, i_grey_shift0})  - $signed({2'b00, i_grey_shift180});
        cos_t = $signed({2'b00, i_grey_shift90}) - $signed({2'b00, i_grey_shift270});
        if (cos_t[DIFF_W-1]) begin
            x0        = -cos_t;
            y0        = -sin_t;
            n_pre.ang = {1'b1, {(ANG_W-1){1'b0}}};
        end else begin
            x0        = cos_t;
            y0        = sin_t;
            n_pre.ang = '0;
        end
        n_pre.x    = {{(CORDIC_W-DIFF_W-PRESCALE){x0[DIFF_W-1]}}, x0, {PRESCALE{1'b0}}};
        n_pre.y    = {{(CORDIC_W-DIFF_W-PRESCALE){y0[DIFF_W-1]}}, y0, {PRESCALE{1'b0}}};
        // both terms zero: phase is forced to zero downstream
        n_pre.zero = (sin_t == '0) && (cos_t == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (pipe_en) begin
            r_pre_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_pre <= n_pre;
        end
    end

    assign cell_data[0]  = r_pre;
    assign cell_valid[0] = r_pre_valid;

    // Chain of vectoring cells; each drives y toward zero by one step.
    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cell
        fspd_cordic_cell #(
            .ITER (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_valid (cell_valid[g]),
            .i_data  (cell_data[g]),
            .o_valid (cell_valid[g+1]),
            .o_data  (cell_data[g+1])
        );
    end

    // Round the angle, scale by the period, add one half and wrap.
    fspd_scale #(
        .PHASE_BITS (PHASE_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (cell_valid[CORDIC_ITERS]),
        .i_ang    (cell_data[CORDIC_ITERS].ang),
        .i_zero   (cell_data[CORDIC_ITERS].zero),
        .i_period (r_period),
        .o_valid  (o_out_valid),
        .o_offset (o_pixel_offset)
    );

endmodule

>>> src/fspd_cordic_cell.sv
// One CORDIC vectoring iteration, registered.
// Depends on fspd_pkg for the vector type and the arctangent table.
module fspd_cordic_cell import fspd_pkg::*; #(
    parameter int ITER = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_cordic i_data,
    output logic    o_valid,
    output t_cordic o_data
);

    logic    r_valid;
    t_cordic r_data;
    t_cordic n_data;
    logic    y_pos;

    always_comb begin
        y_pos       = !i_data.y[CORDIC_W-1] && (i_data.y != '0);
        n_data.zero = i_data.zero;
        if (y_pos) begin
            n_data.x   = i_data.x + (i_data.y >>> ITER);
            n_data.y   = i_data.y - (i_data.x >>> ITER);
            n_data.ang = i_data.ang + ATAN_TURN[ITER];
        end else begin
            n_data.x   = i_data.x - (i_data.y >>> ITER);
            n_data.y   = i_data.y + (i_data.x >>> ITER);
            n_data.ang = i_data.ang - ATAN_TURN[ITER];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> src/fspd_scale.sv
// Phase rounding, scaling by the fringe period and wrap into the period.
// Three registered stages; depends on fspd_pkg for widths.
module fspd_scale import fspd_pkg::*; #(
    parameter int PHASE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [ANG_W-1:0]    i_ang,
    input  logic                i_zero,
    input  logic [PERIOD_W-1:0] i_period,
    output logic                o_valid,
    output logic [OFFSET_W-1:0] o_offset
);

    localparam int FX_W   = PERIOD_W + 8;
    localparam int PROD_W = PHASE_BITS + FX_W;

    logic [2:0]              r_valid;
    logic [PHASE_BITS-1:0]   r_phase;
    logic [PHASE_BITS-1:0]   n_phase;
    logic [PROD_W-1:0]       r_prod;
    logic [OFFSET_W-1:0]     r_offset;
    logic [OFFSET_W-1:0]     n_offset;
    logic [ANG_W-1:0]        ang_rnd;
    logic [FX_W-1:0]         period_fx;
    logic [PROD_W:0]         prod_rnd;
    logic [FX_W:0]           val;

    assign period_fx = {i_period, 8'h00};

    always_comb begin
        // round to PHASE_BITS; a full turn wraps to zero
        ang_rnd = i_ang + (ANG_W'(1) << (ANG_W - 1 - PHASE_BITS));
        n_phase = i_zero ? '0 : ang_rnd[ANG_W-1 -: PHASE_BITS];

        prod_rnd = {1'b0, r_prod} + ((PROD_W+1)'(1) << (PHASE_BITS - 1));
        val      = prod_rnd[PROD_W -: (FX_W+1)] + (FX_W+1)'(128);
        if (val > {1'b0, period_fx}) begin
            val = val - {1'b0, period_fx};
        end
        n_offset = val[OFFSET_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phase  <= n_phase;
            r_prod   <= PROD_W'(r_phase) * PROD_W'(period_fx);
            r_offset <= n_offset;
        end
    end

    assign o_valid  = r_valid[2];
    assign o_offset = r_offset;

endmodule
